// ===== sv/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg - shared definitions for the text console character writer
// Command codes, control characters, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

  // Input command selector
  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Control characters handled by a put
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_COL  = 2'd0;
  localparam logic [1:0] REG_MAX_ROW  = 2'd1;
  localparam logic [1:0] REG_FG_COLOR = 2'd2;
  localparam logic [1:0] REG_BG_COLOR = 2'd3;

  // Field widths
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned CFG_DATA_W = 7;

  // Attribute byte: background in bits 6..4, foreground in bits 3..0
  function automatic logic [7:0] attr_byte(input logic [3:0] fg, input logic [2:0] bg);
    return {1'b0, bg, fg};
  endfunction

endpackage

`default_nettype wire

// ===== sv/text_console_char_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_char_writer - text-mode console character engine
// Screen store of char/attribute cells with a cursor; put, set cursor, read.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one command per transfer: tuser = cmd, tdata = ch, col,
//    row. m_axis returns the results; a tab yields TAB_WIDTH results, all
//    other commands one, and tlast marks the final result of the command.
//  - cfg_* writes max_col, max_row, fg_color, bg_color; always ready. Write
//    only while no command is in flight.
//  - Row/column addressing uses one shared multiply-add unit (row * width + col),
//    stepped by a small sequencer; s_axis_tready is low while a command runs.
//  - A put or backspace runs decode, cell write, position and output hand-off;
//    a new line, set cursor, unknown command or out-of-range read skips the
//    cell write; a read adds address and data states; a further tab space
//    repeats cell write, position and hand-off. A scroll runs init, move and
//    clear: one cell is moved or cleared per cycle through the single store port pair.
//  - After reset a clearing pass writes zero to all STORE_CELLS cells, one
//    per cycle, before the first command is accepted; config writes are
//    taken during that pass.
//  - The result sits in an output register; a new command is accepted while
//    it waits. If the receiver stalls, the sequencer holds before the next
//    result until the register empties.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
  parameter int unsigned STORE_CELLS = 4096,
  parameter int unsigned TAB_WIDTH   = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [tccw_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // ch[7:0], col[15:8], row[21:16]
  input  wire logic [1:0]                        s_axis_tuser,  // cmd[1:0]
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [tccw_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // cell_addr[11:0], char_out[19:12],
                                                                // attr_out[27:20], cursor_col[34:28],
                                                                // cursor_row[39:35], cursor_pos[51:40],
                                                                // scrolled[52]
  output logic                                   m_axis_tuser,  // wrote[0]
  output logic                                   m_axis_tlast,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [1:0]                        cfg_index_i,
  input  wire logic [tccw_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(STORE_CELLS);
  localparam int unsigned XW = (AW > tccw_pkg::ADDR_W) ? AW : tccw_pkg::ADDR_W;
  localparam int unsigned TW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_CELL, S_RDADDR, S_RDDATA,
    S_SC_INIT, S_SC_MOVE, S_SC_CLR, S_POS, S_OUT
  } state_e;

  // linear index lies inside the store
  function automatic logic in_store(input logic [tccw_pkg::ADDR_W-1:0] a);
    return 32'(a) < 32'(STORE_CELLS);
  endfunction

  // linear index to store address
  function automatic logic [AW-1:0] to_idx(input logic [tccw_pkg::ADDR_W-1:0] a);
    logic [XW-1:0] e;
    e = XW'(a);
    return e[AW-1:0];
  endfunction

  state_e state_q;

  // configuration
  logic [6:0] max_col_q;
  logic [4:0] max_row_q;
  logic [3:0] fg_q;
  logic [2:0] bg_q;

  // cursor and latched command
  logic [6:0] cur_x_q;
  logic [4:0] cur_y_q;
  logic [1:0] cmd_q;
  logic [7:0] ch_q;
  logic [7:0] col_q;
  logic [5:0] row_q;
  logic [7:0] char_q;
  logic       adv_q;
  logic       is_tab_q;
  logic [TW-1:0] tab_cnt_q;

  // result under construction
  logic        res_wrote_q;
  logic [11:0] res_addr_q;
  logic [7:0]  res_char_q;
  logic [7:0]  res_attr_q;
  logic        res_scr_q;
  logic [11:0] pos_q;

  // scroll / clear bookkeeping
  logic [AW-1:0] clr_q;
  logic [11:0]   i_q;
  logic [11:0]   moved_q;
  logic [11:0]   wi_q;
  logic          pend_q;
  logic          src_ok_q;

  // output register
  logic        m_valid_q;
  logic        m_wrote_q;
  logic [11:0] m_addr_q;
  logic [7:0]  m_char_q;
  logic [7:0]  m_attr_q;
  logic [6:0]  m_ccol_q;
  logic [4:0]  m_crow_q;
  logic [11:0] m_pos_q;
  logic        m_scr_q;
  logic        m_last_q;

  // screen store
  logic [15:0]   mem_q [STORE_CELLS];
  logic [15:0]   mem_rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  // shared multiply-add unit: mul_y * width + mul_x
  logic [4:0]  mul_y;
  logic [6:0]  mul_x;
  logic [11:0] mul_res;
  logic [7:0]  width;

  logic [7:0]  attr;
  logic [7:0]  x_inc;
  logic [5:0]  y_inc;
  logic        col_over;
  logic        nl_over;
  logic [7:0]  col_m1;
  logic [5:0]  row_m1;
  logic        set_ok;
  logic        rd_ok;
  logic [11:0] src_addr;
  logic [11:0] clr_end;
  logic        out_free;
  logic        res_last;
  logic        in_xfer;

  assign width    = {1'b0, max_col_q} + 8'd1;
  assign attr     = tccw_pkg::attr_byte(fg_q, bg_q);
  assign x_inc    = {1'b0, cur_x_q} + 8'd1;
  assign y_inc    = {1'b0, cur_y_q} + 6'd1;
  assign col_over = x_inc > {1'b0, max_col_q};
  assign nl_over  = y_inc > {1'b0, max_row_q};
  assign col_m1   = col_q - 8'd1;
  assign row_m1   = row_q - 6'd1;
  assign set_ok   = (col_q != 8'd0) && (col_q <= width) &&
                    (row_q != 6'd0) && (row_q <= ({1'b0, max_row_q} + 6'd1));
  assign rd_ok    = (col_q <= {1'b0, max_col_q}) && (row_q <= {1'b0, max_row_q});
  assign src_addr = i_q + 12'(width);
  assign clr_end  = moved_q + 12'(width) - 12'd1;
  assign out_free = !m_valid_q || m_axis_tready;
  assign res_last = !is_tab_q || (tab_cnt_q == TW'(TAB_WIDTH - 1));
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // operand select for the shared unit
  always_comb begin
    mul_y = cur_y_q;
    mul_x = cur_x_q;
    unique case (state_q)
      S_RDADDR: begin
        mul_y = row_q[4:0];
        mul_x = col_q[6:0];
      end
      S_SC_INIT: begin
        mul_y = max_row_q;
        mul_x = 7'd0;
      end
      default: begin
        mul_y = cur_y_q;
        mul_x = cur_x_q;
      end
    endcase
  end

  assign mul_res = 12'(mul_y) * 12'(width) + 12'(mul_x);

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = to_idx(mul_res);
    mem_wd = 16'd0;
    mem_ra = to_idx(mul_res);
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
      end
      S_CELL: begin
        mem_we = in_store(mul_res);
        mem_wd = {attr, char_q};
      end
      S_SC_MOVE: begin
        mem_ra = to_idx(src_addr);
        mem_we = pend_q && in_store(wi_q);
        mem_wa = to_idx(wi_q);
        mem_wd = src_ok_q ? mem_rd_q : 16'd0;
      end
      S_SC_CLR: begin
        mem_we = in_store(i_q);
        mem_wa = to_idx(i_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // screen store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem_q[mem_ra];
  end

  // sequencer, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      max_col_q   <= 7'd79;
      max_row_q   <= 5'd24;
      fg_q        <= 4'd7;
      bg_q        <= 3'd0;
      cur_x_q     <= 7'd0;
      cur_y_q     <= 5'd0;
      cmd_q       <= tccw_pkg::CMD_PUT;
      ch_q        <= 8'd0;
      col_q       <= 8'd0;
      row_q       <= 6'd0;
      char_q      <= 8'd0;
      adv_q       <= 1'b0;
      is_tab_q    <= 1'b0;
      tab_cnt_q   <= '0;
      res_wrote_q <= 1'b0;
      res_addr_q  <= 12'd0;
      res_char_q  <= 8'd0;
      res_attr_q  <= 8'd0;
      res_scr_q   <= 1'b0;
      pos_q       <= 12'd0;
      clr_q       <= '0;
      i_q         <= 12'd0;
      moved_q     <= 12'd0;
      wi_q        <= 12'd0;
      pend_q      <= 1'b0;
      src_ok_q    <= 1'b0;
      m_valid_q   <= 1'b0;
      m_wrote_q   <= 1'b0;
      m_addr_q    <= 12'd0;
      m_char_q    <= 8'd0;
      m_attr_q    <= 8'd0;
      m_ccol_q    <= 7'd0;
      m_crow_q    <= 5'd0;
      m_pos_q     <= 12'd0;
      m_scr_q     <= 1'b0;
      m_last_q    <= 1'b0;
    end else begin
      // configuration transfer
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tccw_pkg::REG_MAX_COL:  max_col_q <= cfg_data_i[6:0];
          tccw_pkg::REG_MAX_ROW:  max_row_q <= cfg_data_i[4:0];
          tccw_pkg::REG_FG_COLOR: fg_q      <= cfg_data_i[3:0];
          tccw_pkg::REG_BG_COLOR: bg_q      <= cfg_data_i[2:0];
          default:                fg_q      <= fg_q;
        endcase
      end

      // output register drains
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        // zero the store after reset
        S_CLEAR: begin
          if (clr_q == AW'(STORE_CELLS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_xfer) begin
            cmd_q   <= s_axis_tuser;
            ch_q    <= s_axis_tdata[7:0];
            col_q   <= s_axis_tdata[15:8];
            row_q   <= s_axis_tdata[21:16];
            state_q <= S_EXEC;
          end
        end

        // decode the command
        S_EXEC: begin
          res_wrote_q <= 1'b0;
          res_addr_q  <= 12'd0;
          res_char_q  <= 8'd0;
          res_attr_q  <= 8'd0;
          res_scr_q   <= 1'b0;
          is_tab_q    <= 1'b0;
          tab_cnt_q   <= '0;
          state_q     <= S_POS;
          unique case (cmd_q)
            tccw_pkg::CMD_PUT: begin
              if (ch_q == tccw_pkg::CH_CR || ch_q == tccw_pkg::CH_LF) begin
                cur_x_q <= 7'd0;
                if (nl_over) begin
                  cur_y_q   <= max_row_q;
                  res_scr_q <= 1'b1;
                  state_q   <= S_SC_INIT;
                end else begin
                  cur_y_q <= y_inc[4:0];
                end
              end else if (ch_q == tccw_pkg::CH_TAB) begin
                is_tab_q <= 1'b1;
                char_q   <= tccw_pkg::CH_SPACE;
                adv_q    <= 1'b1;
                state_q  <= S_CELL;
              end else if (ch_q == tccw_pkg::CH_BS) begin
                // step back, wrapping to the end of the previous row
                if (cur_x_q != 7'd0) begin
                  cur_x_q <= cur_x_q - 7'd1;
                end else if (cur_y_q != 5'd0) begin
                  cur_x_q <= max_col_q;
                  cur_y_q <= cur_y_q - 5'd1;
                end
                char_q  <= tccw_pkg::CH_SPACE;
                adv_q   <= 1'b0;
                state_q <= S_CELL;
              end else begin
                char_q  <= ch_q;
                adv_q   <= 1'b1;
                state_q <= S_CELL;
              end
            end
            tccw_pkg::CMD_SET: begin
              if (set_ok) begin
                cur_x_q <= col_m1[6:0];
                cur_y_q <= row_m1[4:0];
              end
            end
            tccw_pkg::CMD_READ: begin
              if (rd_ok) begin
                state_q <= S_RDADDR;
              end
            end
            default: begin
              state_q <= S_POS;
            end
          endcase
        end

        // write one cell at the cursor, then advance unless it is a backspace
        S_CELL: begin
          res_wrote_q <= 1'b1;
          res_addr_q  <= mul_res;
          res_char_q  <= char_q;
          res_attr_q  <= attr;
          res_scr_q   <= 1'b0;
          state_q     <= S_POS;
          if (adv_q) begin
            if (col_over) begin
              cur_x_q <= 7'd0;
              if (nl_over) begin
                cur_y_q   <= max_row_q;
                res_scr_q <= 1'b1;
                state_q   <= S_SC_INIT;
              end else begin
                cur_y_q <= y_inc[4:0];
              end
            end else begin
              cur_x_q <= x_inc[6:0];
            end
          end
        end

        // read: address issued here, registered data taken in the next cycle
        S_RDADDR: begin
          res_addr_q <= mul_res;
          src_ok_q   <= in_store(mul_res);
          state_q    <= S_RDDATA;
        end

        S_RDDATA: begin
          res_char_q <= src_ok_q ? mem_rd_q[7:0] : 8'd0;
          res_attr_q <= src_ok_q ? mem_rd_q[15:8] : 8'd0;
          state_q    <= S_POS;
        end

        // scroll: moved = max_row * width
        S_SC_INIT: begin
          moved_q <= mul_res;
          i_q     <= 12'd0;
          pend_q  <= 1'b0;
          state_q <= S_SC_MOVE;
        end

        // copy cell i+width down to i, read and write overlapped
        S_SC_MOVE: begin
          if (i_q < moved_q) begin
            pend_q   <= 1'b1;
            wi_q     <= i_q;
            src_ok_q <= in_store(src_addr);
            i_q      <= i_q + 12'd1;
          end else begin
            pend_q  <= 1'b0;
            state_q <= S_SC_CLR;
          end
        end

        // blank the last row
        S_SC_CLR: begin
          if (i_q == clr_end) begin
            state_q <= S_POS;
          end else begin
            i_q <= i_q + 12'd1;
          end
        end

        S_POS: begin
          pos_q   <= mul_res;
          state_q <= S_OUT;
        end

        // hand the result to the output register
        S_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_wrote_q <= res_wrote_q;
            m_addr_q  <= res_addr_q;
            m_char_q  <= res_char_q;
            m_attr_q  <= res_attr_q;
            m_ccol_q  <= cur_x_q;
            m_crow_q  <= cur_y_q;
            m_pos_q   <= pos_q;
            m_scr_q   <= res_scr_q;
            m_last_q  <= res_last;
            if (res_last) begin
              state_q <= S_IDLE;
            end else begin
              tab_cnt_q <= tab_cnt_q + 1'b1;
              state_q   <= S_CELL;
            end
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_wrote_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {3'd0, m_scr_q, m_pos_q, m_crow_q, m_ccol_q,
                          m_attr_q, m_char_q, m_addr_q};

`ifndef ASSERT_OFF
  // an accepted command goes straight to decode
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EXEC))
    else $error("accepted command did not enter decode");

  // scroll copy never writes at or above the cell being read
  a_scroll_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SC_MOVE && pend_q) |-> (wi_q < i_q))
    else $error("scroll write overtook its read");

  // only tab spaces produce results that are not the last of a command
  a_nonlast_wrote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser)
    else $error("non-final result without a written cell");

  // after a scroll the cursor sits on the last row
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_scr_q) |-> (m_crow_q == max_row_q))
    else $error("scrolled result with cursor off the last row");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - text console character writer
// Drives put, set-cursor, read and unused commands through the command
// stream. A screen tracker keeps its own copy of the cells, cursor and
// geometry, builds the results each command should give, and checks the
// result stream against them field by field. Each random phase sets its own
// geometry, colors and idle pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned STORE_SIZE   = 4096;
  localparam int unsigned TAB_SPACES   = 8;
  localparam int unsigned QUIET_LIMIT  = 30000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 50;
  // command code the block does not define
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct {
    bit        wrote;
    bit [11:0] cell_addr;
    bit [7:0]  char_out;
    bit [7:0]  attr_out;
    bit [6:0]  cursor_col;
    bit [4:0]  cursor_row;
    bit [11:0] cursor_pos;
    bit        scrolled;
    bit        last;
  } console_result_t;

  // --------------------------------------------------------------------------
  // Screen tracker: own copy of the screen, cursor and registers; queue of
  // results still due from the block.
  // --------------------------------------------------------------------------
  class screen_tracker;
    bit [15:0]       cells [STORE_SIZE];
    int unsigned     cur_x, cur_y;
    int unsigned     last_col, last_row;
    bit [3:0]        fg;
    bit [2:0]        bg;
    console_result_t due_results[$];
    int unsigned     mismatches;

    function new();
      cur_x = 0;
      cur_y = 0;
      last_col = 79;
      last_row = 24;
      fg = 4'd7;
      bg = 3'd0;
      mismatches = 0;
    endfunction

    function void write_register(bit [1:0] idx, bit [6:0] value);
      case (idx)
        tccw_pkg::REG_MAX_COL:  last_col = 32'(value);
        tccw_pkg::REG_MAX_ROW:  last_row = 32'(value[4:0]);
        tccw_pkg::REG_FG_COLOR: fg = value[3:0];
        tccw_pkg::REG_BG_COLOR: bg = value[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned cell_index(int unsigned x, int unsigned y);
      return y * (last_col + 1) + x;
    endfunction

    function bit [15:0] fetch(int unsigned a);
      return (a < STORE_SIZE) ? cells[a] : 16'd0;
    endfunction

    function void store(int unsigned a, bit [15:0] v);
      if (a < STORE_SIZE) cells[a] = v;
    endfunction

    function bit [7:0] attr();
      return {1'b0, bg, fg};
    endfunction

    // move every row up by one and blank the bottom row
    function void scroll_screen();
      int unsigned w;
      int unsigned moved;
      w = last_col + 1;
      moved = last_row * w;
      for (int unsigned i = 0; i < moved; i++) store(i, fetch(i + w));
      for (int unsigned i = 0; i < w; i++) store(moved + i, 16'd0);
    endfunction

    // returns 1 when the new line ran past the bottom row
    function bit next_line();
      cur_x = 0;
      cur_y = cur_y + 1;
      if (cur_y > last_row) begin
        cur_y = last_row;
        scroll_screen();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // write a glyph at the cursor and advance, wrapping at the right edge
    function int unsigned put_glyph(bit [7:0] c, output bit sc);
      int unsigned a;
      a = cell_index(cur_x, cur_y);
      store(a, {attr(), c});
      cur_x = cur_x + 1;
      sc = 1'b0;
      if (cur_x > last_col) sc = next_line();
      return a;
    endfunction

    function void expect_result(bit wrote, int unsigned addr, bit [7:0] c, bit [7:0] at,
                                bit sc, bit lst);
      console_result_t r;
      int unsigned     pos;
      pos          = cell_index(cur_x, cur_y);
      r.wrote      = wrote;
      r.cell_addr  = addr[11:0];
      r.char_out   = c;
      r.attr_out   = at;
      r.cursor_col = cur_x[6:0];
      r.cursor_row = cur_y[4:0];
      r.cursor_pos = pos[11:0];
      r.scrolled   = sc;
      r.last       = lst;
      due_results.push_back(r);
    endfunction

    // work out the results of one accepted command
    function void accept_command(bit [1:0] cmd, bit [7:0] ch, bit [7:0] col, bit [5:0] row);
      int unsigned a;
      bit          sc;
      bit [15:0]   v;
      sc = 1'b0;
      case (cmd)
        tccw_pkg::CMD_PUT: begin
          if (ch == tccw_pkg::CH_CR || ch == tccw_pkg::CH_LF) begin
            sc = next_line();
            expect_result(1'b0, 0, 8'd0, 8'd0, sc, 1'b1);
          end else if (ch == tccw_pkg::CH_TAB) begin
            for (int k = 0; k < TAB_SPACES; k++) begin
              a = put_glyph(tccw_pkg::CH_SPACE, sc);
              expect_result(1'b1, a, tccw_pkg::CH_SPACE, attr(), sc, k == TAB_SPACES - 1);
            end
          end else if (ch == tccw_pkg::CH_BS) begin
            // step back, wrapping to the end of the row above; stay at top left
            if (cur_x > 0) begin
              cur_x = cur_x - 1;
            end else if (cur_y > 0) begin
              cur_x = last_col;
              cur_y = cur_y - 1;
            end
            a = cell_index(cur_x, cur_y);
            store(a, {attr(), tccw_pkg::CH_SPACE});
            expect_result(1'b1, a, tccw_pkg::CH_SPACE, attr(), 1'b0, 1'b1);
          end else begin
            a = put_glyph(ch, sc);
            expect_result(1'b1, a, ch, attr(), sc, 1'b1);
          end
        end
        tccw_pkg::CMD_SET: begin
          // 1-based; ignored when either coordinate is off screen
          if (col >= 1 && col <= last_col + 1 && row >= 1 && row <= last_row + 1) begin
            cur_x = 32'(col) - 1;
            cur_y = 32'(row) - 1;
          end
          expect_result(1'b0, 0, 8'd0, 8'd0, 1'b0, 1'b1);
        end
        tccw_pkg::CMD_READ: begin
          if (col <= last_col && row <= last_row) begin
            a = cell_index(32'(col), 32'(row));
            v = fetch(a);
            expect_result(1'b0, a, v[7:0], v[15:8], 1'b0, 1'b1);
          end else begin
            expect_result(1'b0, 0, 8'd0, 8'd0, 1'b0, 1'b1);
          end
        end
        default: expect_result(1'b0, 0, 8'd0, 8'd0, 1'b0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(console_result_t got);
      console_result_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("wrote",      want.wrote,      got.wrote);
      compare_field("cell_addr",  want.cell_addr,  got.cell_addr);
      compare_field("char_out",   want.char_out,   got.char_out);
      compare_field("attr_out",   want.attr_out,   got.attr_out);
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("cursor_pos", want.cursor_pos, got.cursor_pos);
      compare_field("scrolled",   want.scrolled,   got.scrolled);
      compare_field("last",       want.last,       got.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tccw_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tccw_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_index_i = '0;
  logic [tccw_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  screen_tracker tracker;
  int unsigned   sender_idle_pct = 0;
  int unsigned   receiver_stall_pct = 0;
  int unsigned   hold_requests = 0;
  int unsigned   hold_taken = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;

  text_console_char_writer #(
    .STORE_CELLS(STORE_SIZE),
    .TAB_WIDTH  (TAB_SPACES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // ch[7:0], col[15:8], row[21:16]
    .s_axis_tuser (s_axis_tuser),   // cmd[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // cell_addr, char_out, attr_out, cursor_col,
                                    // cursor_row, cursor_pos, scrolled
    .m_axis_tuser (m_axis_tuser),   // wrote[0]
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_requests != hold_taken) begin
      hold_taken = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    console_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.wrote      = m_axis_tuser;
      got.cell_addr  = m_axis_tdata[11:0];
      got.char_out   = m_axis_tdata[19:12];
      got.attr_out   = m_axis_tdata[27:20];
      got.cursor_col = m_axis_tdata[34:28];
      got.cursor_row = m_axis_tdata[39:35];
      got.cursor_pos = m_axis_tdata[51:40];
      got.scrolled   = m_axis_tdata[52];
      got.last       = m_axis_tlast;
      tracker.check_result(got);
    end
  end

  // Watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** text_console_char_writer: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // write all four registers back to back; valid stays high across them
  task automatic write_registers(bit [6:0] mc, bit [6:0] mr, bit [6:0] fgv, bit [6:0] bgv);
    bit [6:0] vals [4];
    bit [1:0] idx  [4];
    vals = '{mc, mr, fgv, bgv};
    idx  = '{tccw_pkg::REG_MAX_COL, tccw_pkg::REG_MAX_ROW,
             tccw_pkg::REG_FG_COLOR, tccw_pkg::REG_BG_COLOR};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.write_register(idx[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // offer one command; valid is left high for the next one
  task automatic send_command(bit [1:0] cmd, bit [7:0] ch, bit [7:0] col, bit [5:0] row);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, row, col, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.accept_command(cmd, ch, col, row);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    bit [1:0]    cmd;
    bit [7:0]    ch;
    bit [7:0]    col;
    bit [5:0]    row;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    col  = 8'($urandom_range(255));
    row  = 6'($urandom_range(63));
    if (pick < 55) begin
      cmd = tccw_pkg::CMD_PUT;
      case ($urandom_range(9))
        0: ch = tccw_pkg::CH_CR;
        1: ch = tccw_pkg::CH_LF;
        2: ch = tccw_pkg::CH_TAB;
        3: ch = tccw_pkg::CH_BS;
        default: ;
      endcase
    end else if (pick < 70) begin
      cmd = tccw_pkg::CMD_SET;
      // mostly on screen, sometimes anything the fields hold
      if ($urandom_range(9) != 0) begin
        col = 8'($urandom_range(tracker.last_col + 1, 1));
        row = 6'($urandom_range(tracker.last_row + 1, 1));
      end
    end else if (pick < 95) begin
      cmd = tccw_pkg::CMD_READ;
      if ($urandom_range(9) != 0) begin
        col = 8'($urandom_range(tracker.last_col, 0));
        row = 6'($urandom_range(tracker.last_row, 0));
      end
    end else begin
      cmd = CMD_UNUSED;
    end
    send_command(cmd, ch, col, row);
  endtask

  // drop valid and wait for every outstanding result
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.due_results.size() != 0);
  endtask

  task automatic run_phase(bit [6:0] mc, bit [6:0] mr, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned count, bit with_hold);
    write_registers(mc, mr, 7'($urandom_range(15)), 7'($urandom_range(7)));
    sender_idle_pct = idle_pct;
    receiver_stall_pct <= stall_pct;
    for (int unsigned i = 0; i < count; i++) begin
      if (with_hold && i == 20) hold_requests <= hold_requests + 1;
      send_random_item();
    end
    finish_phase();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed checks at reset geometry (80 x 25)
    send_command(tccw_pkg::CMD_READ, 8'd0, 8'd0, 6'd0);           // cleared cell
    send_command(tccw_pkg::CMD_PUT, 8'd65, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_PUT, 8'd0, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_PUT, 8'd255, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_READ, 8'd0, 8'd2, 6'd0);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_CR, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_LF, 8'd0, 6'd0);
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd1, 6'd1);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 8'd0, 6'd0);  // top left: stays put
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd1, 6'd2);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_BS, 8'd0, 6'd0);  // wraps to end of row 0
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd80, 6'd25);
    send_command(tccw_pkg::CMD_PUT, 8'd122, 8'd0, 6'd0);          // bottom right: wrap, scroll
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd81, 6'd1);           // off screen, ignored
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd0, 6'd5);
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd1, 6'd26);
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd80, 6'd25);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_LF, 8'd0, 6'd0);  // new line at bottom scrolls
    send_command(tccw_pkg::CMD_SET, 8'd0, 8'd77, 6'd3);
    send_command(tccw_pkg::CMD_PUT, tccw_pkg::CH_TAB, 8'd0, 6'd0); // tab across the line end
    send_command(tccw_pkg::CMD_READ, 8'd0, 8'd80, 6'd0);          // out of range reads
    send_command(tccw_pkg::CMD_READ, 8'd0, 8'd0, 6'd25);
    send_command(tccw_pkg::CMD_READ, 8'd255, 8'd255, 6'd63);
    send_command(tccw_pkg::CMD_READ, 8'd0, 8'd79, 6'd24);
    send_command(CMD_UNUSED, 8'd255, 8'd255, 6'd63);
    finish_phase();

    // random phases: geometry, idle pattern, count
    run_phase(7'd15,  7'd3,  0,  0,  100, 1'b1);        // long receiver hold inside
    run_phase(7'd7,   7'd1,  53, 0,  100, 1'b0);
    run_phase(7'd127, 7'd31, 0,  53, 60,  1'b0);        // largest screen
    run_phase(7'd1,   7'd1,  33, 33, 80,  1'b0);        // smallest screen
    run_phase(7'd39,  7'd11, 33, 33, 60,  1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0) begin
      $display("** text_console_char_writer: PASSED **");
    end else begin
      $display("** text_console_char_writer: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
